@@ rtl/mos_pkg.sv @@
// Shared constants and types for the median-of-loaded-set block.
`default_nettype none

package mos_pkg;

  localparam int SET_DEPTH = 256;
  localparam int ADDR_W    = $clog2(SET_DEPTH);
  localparam int CNT_W     = $clog2(SET_DEPTH + 1);
  localparam int VAL_W     = 32;
  localparam int MED_W     = VAL_W + 1;
  localparam int SETC_W    = 9;
  localparam int DIG_W     = 4;
  localparam int NUM_BKT   = 1 << DIG_W;
  localparam int BKT_W     = DIG_W;
  localparam int SHAMT_W   = $clog2(VAL_W);

  // Flipping the sign bit maps signed order onto unsigned order.
  localparam logic [VAL_W-1:0] SIGN_FLIP = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [VAL_W-1:0] BKT_MASK  = VAL_W'(NUM_BKT - 1);
  localparam logic [SHAMT_W-1:0] TOP_SHAMT = SHAMT_W'(VAL_W - DIG_W);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_RANK_A,
    ST_RANK_B,
    ST_FINISH
  } top_state_t;

  typedef enum logic [1:0] {
    SEL_IDLE,
    SEL_COUNT,
    SEL_SCAN
  } sel_state_t;

  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] rank;
    logic [CNT_W-1:0]  count;
  } sel_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] value;
  } sel_rsp_t;

endpackage

`default_nettype wire

@@ rtl/median_of_loaded_set.sv @@
// Median of a loaded set: value store, rank selection and result register.
// Loading accepts one request per cycle; in_ready is high whenever a set is loading.
// After the closing request the selector runs twice (ranks (n-1)/2 and n/2), each
// run 8 radix-16 passes, each a read of all n stored values and then a bucket scan;
// out_valid then rises as soon as no earlier result is left waiting.
// Reset (rst_n low, synchronous) clears the fill count, overflow flag and valids.
`default_nettype none

module median_of_loaded_set (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input requests
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [mos_pkg::VAL_W-1:0] in_sample_value,
  input  wire logic                          in_last_value,
  // result requests
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [mos_pkg::MED_W-1:0]   out_median_doubled,
  output logic [mos_pkg::SETC_W-1:0]         out_set_count,
  output logic                               out_overflowed,
  output logic                               out_empty_set
);

  mos_pkg::top_state_t             state_r, state_nxt;
  logic [mos_pkg::CNT_W-1:0]       fill_r, fill_nxt;
  logic                            ovf_r, ovf_nxt;
  logic [mos_pkg::VAL_W-1:0]       val_a_r, val_a_nxt;
  logic [mos_pkg::VAL_W-1:0]       val_b_r, val_b_nxt;

  // result register: decouples the selector from the downstream stall
  logic                            out_valid_r, out_valid_nxt;
  logic [mos_pkg::MED_W-1:0]       median_r, median_nxt;
  logic [mos_pkg::SETC_W-1:0]      count_r, count_nxt;
  logic                            ovf_out_r, ovf_out_nxt;
  logic                            empty_r, empty_nxt;

  logic                            in_fire;
  logic                            has_room;
  logic [mos_pkg::CNT_W-1:0]       fill_inc;

  logic                            wr_en;
  logic [mos_pkg::ADDR_W-1:0]      rd_addr;
  logic [mos_pkg::VAL_W-1:0]       rd_data;

  mos_pkg::sel_req_t               sel_req;
  mos_pkg::sel_rsp_t               sel_rsp;

  assign in_ready = state_r == mos_pkg::ST_LOAD;
  assign in_fire  = in_valid && in_ready;
  assign has_room = fill_r < mos_pkg::CNT_W'(mos_pkg::SET_DEPTH);
  assign fill_inc = fill_r + mos_pkg::CNT_W'(has_room);
  assign wr_en    = in_fire && has_room;

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    ovf_nxt       = ovf_r;
    val_a_nxt     = val_a_r;
    val_b_nxt     = val_b_r;
    out_valid_nxt = out_valid_r && !out_ready;
    median_nxt    = median_r;
    count_nxt     = count_r;
    ovf_out_nxt   = ovf_out_r;
    empty_nxt     = empty_r;
    sel_req       = '0;

    unique case (state_r)
      mos_pkg::ST_LOAD: begin
        if (in_fire) begin
          fill_nxt = fill_inc;
          if (!has_room) begin
            ovf_nxt = 1'b1;
          end
          if (in_last_value) begin
            if (fill_inc == '0) begin
              state_nxt = mos_pkg::ST_FINISH;
            end else begin
              // lower middle rank first
              sel_req.start = 1'b1;
              sel_req.count = fill_inc;
              sel_req.rank  = mos_pkg::ADDR_W'((fill_inc - 1'b1) >> 1);
              state_nxt     = mos_pkg::ST_RANK_A;
            end
          end
        end
      end

      mos_pkg::ST_RANK_A: begin
        if (sel_rsp.done) begin
          val_a_nxt = sel_rsp.value;
          // upper middle rank; equals the lower one for an odd count
          sel_req.start = 1'b1;
          sel_req.count = fill_r;
          sel_req.rank  = mos_pkg::ADDR_W'(fill_r >> 1);
          state_nxt     = mos_pkg::ST_RANK_B;
        end
      end

      mos_pkg::ST_RANK_B: begin
        if (sel_rsp.done) begin
          val_b_nxt = sel_rsp.value;
          state_nxt = mos_pkg::ST_FINISH;
        end
      end

      mos_pkg::ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (fill_r == '0) begin
            median_nxt = '0;
          end else begin
            median_nxt = {val_a_r[mos_pkg::VAL_W-1], val_a_r}
                       + {val_b_r[mos_pkg::VAL_W-1], val_b_r};
          end
          count_nxt   = mos_pkg::SETC_W'(fill_r);
          ovf_out_nxt = ovf_r;
          empty_nxt   = fill_r == '0;
          fill_nxt    = '0;
          ovf_nxt     = 1'b0;
          state_nxt   = mos_pkg::ST_LOAD;
        end
      end

      default: begin
        state_nxt = mos_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mos_pkg::ST_LOAD;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_a_r   <= val_a_nxt;
    val_b_r   <= val_b_nxt;
    median_r  <= median_nxt;
    count_r   <= count_nxt;
    ovf_out_r <= ovf_out_nxt;
    empty_r   <= empty_nxt;
  end

  // value store: written while loading, read only by the selector
  mos_ram #(
    .WIDTH (mos_pkg::VAL_W),
    .DEPTH (mos_pkg::SET_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill_r[mos_pkg::ADDR_W-1:0]),
    .wr_data (in_sample_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mos_select u_select (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (sel_req),
    .rsp     (sel_rsp),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_valid          = out_valid_r;
  assign out_median_doubled = median_r;
  assign out_set_count      = count_r;
  assign out_overflowed     = ovf_out_r;
  assign out_empty_set      = empty_r;

endmodule

`default_nettype wire

@@ rtl/mos_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mos_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/mos_select.sv @@
// Radix-16 rank selector: finds the element of a given sorted rank in the store.
`default_nettype none

module mos_select (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire mos_pkg::sel_req_t           req,
  output mos_pkg::sel_rsp_t                rsp,
  output logic [mos_pkg::ADDR_W-1:0]       rd_addr,
  input  wire logic [mos_pkg::VAL_W-1:0]   rd_data
);

  mos_pkg::sel_state_t               state_r, state_nxt;
  logic                              done_r, done_nxt;
  logic                              rd_vld_r, rd_vld_nxt;
  logic [mos_pkg::CNT_W-1:0]         addr_r, addr_nxt;
  logic [mos_pkg::CNT_W-1:0]         n_r, n_nxt;
  logic [mos_pkg::CNT_W-1:0]         rank_r, rank_nxt;
  logic [mos_pkg::VAL_W-1:0]         prefix_r, prefix_nxt;
  logic [mos_pkg::VAL_W-1:0]         mask_r, mask_nxt;
  logic [mos_pkg::SHAMT_W-1:0]       shamt_r, shamt_nxt;
  logic [mos_pkg::BKT_W-1:0]         bkt_r, bkt_nxt;
  logic [mos_pkg::CNT_W-1:0]         hist_r   [mos_pkg::NUM_BKT];
  logic [mos_pkg::CNT_W-1:0]         hist_nxt [mos_pkg::NUM_BKT];

  logic [mos_pkg::VAL_W-1:0]         key;
  logic                              match;
  logic [mos_pkg::BKT_W-1:0]         dig;
  logic                              issue;

  assign key     = rd_data ^ mos_pkg::SIGN_FLIP;
  assign match   = ((key ^ prefix_r) & mask_r) == '0;
  assign dig     = mos_pkg::BKT_W'(key >> shamt_r);
  assign issue   = addr_r != n_r;
  assign rd_addr = addr_r[mos_pkg::ADDR_W-1:0];

  always_comb begin
    state_nxt  = state_r;
    done_nxt   = 1'b0;
    rd_vld_nxt = 1'b0;
    addr_nxt   = addr_r;
    n_nxt      = n_r;
    rank_nxt   = rank_r;
    prefix_nxt = prefix_r;
    mask_nxt   = mask_r;
    shamt_nxt  = shamt_r;
    bkt_nxt    = bkt_r;
    for (int i = 0; i < mos_pkg::NUM_BKT; i++) begin
      hist_nxt[i] = hist_r[i];
    end

    unique case (state_r)
      mos_pkg::SEL_IDLE: begin
        if (req.start) begin
          n_nxt      = req.count;
          rank_nxt   = mos_pkg::CNT_W'(req.rank);
          prefix_nxt = '0;
          mask_nxt   = '0;
          shamt_nxt  = mos_pkg::TOP_SHAMT;
          addr_nxt   = '0;
          bkt_nxt    = '0;
          for (int i = 0; i < mos_pkg::NUM_BKT; i++) begin
            hist_nxt[i] = '0;
          end
          state_nxt  = mos_pkg::SEL_COUNT;
        end
      end

      mos_pkg::SEL_COUNT: begin
        // reads stream out one per cycle; read data returns in the cycle after its address
        rd_vld_nxt = issue;
        addr_nxt   = addr_r + mos_pkg::CNT_W'(issue);
        if (rd_vld_r && match) begin
          hist_nxt[dig] = hist_r[dig] + 1'b1;
        end
        if (!issue && !rd_vld_r) begin
          state_nxt = mos_pkg::SEL_SCAN;
        end
      end

      mos_pkg::SEL_SCAN: begin
        // histogram rotates toward entry 0, so only entry 0 is examined
        if (rank_r < hist_r[0]) begin
          prefix_nxt = prefix_r | (mos_pkg::VAL_W'(bkt_r) << shamt_r);
          mask_nxt   = mask_r | (mos_pkg::BKT_MASK << shamt_r);
          bkt_nxt    = '0;
          addr_nxt   = '0;
          for (int i = 0; i < mos_pkg::NUM_BKT; i++) begin
            hist_nxt[i] = '0;
          end
          if (shamt_r == '0) begin
            done_nxt  = 1'b1;
            state_nxt = mos_pkg::SEL_IDLE;
          end else begin
            shamt_nxt = shamt_r - mos_pkg::SHAMT_W'(mos_pkg::DIG_W);
            state_nxt = mos_pkg::SEL_COUNT;
          end
        end else begin
          rank_nxt = rank_r - hist_r[0];
          bkt_nxt  = bkt_r + 1'b1;
          for (int i = 0; i < mos_pkg::NUM_BKT - 1; i++) begin
            hist_nxt[i] = hist_r[i+1];
          end
          hist_nxt[mos_pkg::NUM_BKT-1] = '0;
        end
      end

      default: begin
        state_nxt = mos_pkg::SEL_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= mos_pkg::SEL_IDLE;
      done_r   <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      done_r   <= done_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r   <= addr_nxt;
    n_r      <= n_nxt;
    rank_r   <= rank_nxt;
    prefix_r <= prefix_nxt;
    mask_r   <= mask_nxt;
    shamt_r  <= shamt_nxt;
    bkt_r    <= bkt_nxt;
    for (int i = 0; i < mos_pkg::NUM_BKT; i++) begin
      hist_r[i] <= hist_nxt[i];
    end
  end

  assign rsp.done  = done_r;
  assign rsp.value = prefix_r ^ mos_pkg::SIGN_FLIP;

endmodule

`default_nettype wire

@@ test/median_of_loaded_set_tb.sv @@
// Self-checking testbench for median_of_loaded_set: directed sets, then random sets under flow control.
`default_nettype none

module median_of_loaded_set_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT    = 2_000_000;  // hang guard, far above the slowest legal run
  localparam int LONG_HOLD      = 20000;      // one long out_ready stall, outlasts two full-store selects
  localparam int RANDOM_SAMPLES = 400;        // random sample requests before the tail
  localparam int DRAIN_CYCLES   = 40;         // quiet cycles at the end to catch stray results

  // One median result, field for field as the result port carries it.
  typedef struct packed {
    logic signed [mos_pkg::MED_W-1:0] median_doubled;
    logic [mos_pkg::SETC_W-1:0]       set_count;
    logic                             overflowed;
    logic                             empty_set;
  } median_result_t;

  // One directed row: reps copies of value, last flag only on the final copy.
  // typed rows carry a hand-written result; the rest lean on the predictor.
  typedef struct {
    int unsigned                      reps;
    logic signed [mos_pkg::VAL_W-1:0] value;
    logic                             last;
    bit                               typed;
    median_result_t                   want;
  } script_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                             in_valid        = 1'b0;
  logic                             in_ready;
  logic signed [mos_pkg::VAL_W-1:0] in_sample_value = '0;
  logic                             in_last_value   = 1'b0;

  logic                             out_valid;
  logic                             out_ready       = 1'b0;
  logic signed [mos_pkg::MED_W-1:0] out_median_doubled;
  logic [mos_pkg::SETC_W-1:0]       out_set_count;
  logic                             out_overflowed;
  logic                             out_empty_set;

  median_of_loaded_set dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sample_value    (in_sample_value),
    .in_last_value      (in_last_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_median_doubled (out_median_doubled),
    .out_set_count      (out_set_count),
    .out_overflowed     (out_overflowed),
    .out_empty_set      (out_empty_set)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: the set being loaded, mirrored outside the block.
  int          kept_vals [mos_pkg::SET_DEPTH];
  int unsigned kept_n   = 0;
  bit          kept_ovf = 0;

  median_result_t pending_medians[$];   // predicted medians, oldest first

  int    errors          = 0;
  int    medians_checked = 0;
  int    samples_sent    = 0;
  int    sets_closed     = 0;
  int    ovf_sets        = 0;
  int    largest_set     = 0;
  int    burst_left      = 0;
  int    cycles          = 0;
  bit    random_phase    = 0;
  bit    long_hold_done  = 0;

  script_row_t script[$];

  // Fold one accepted sample into the mirrored set. On a closing sample, work out
  // the median (doubled), clear the set and return 1.
  function automatic bit take_sample(input logic signed [mos_pkg::VAL_W-1:0] v,
                                     input logic l, output median_result_t r);
    int     sorted [mos_pkg::SET_DEPTH];
    int     key;
    int     i;
    int     j;
    longint twice;
    r = '0;
    if (kept_n < mos_pkg::SET_DEPTH) begin
      kept_vals[kept_n] = v;
      kept_n++;
    end else begin
      kept_ovf = 1;   // store full: value dropped, closing one included
    end
    if (!l) return 0;
    // plain insertion sort, true signed order on int
    for (i = 0; i < kept_n; i++) sorted[i] = kept_vals[i];
    for (i = 1; i < kept_n; i++) begin
      key = sorted[i];
      j   = i;
      while (j > 0 && sorted[j-1] > key) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = key;
    end
    twice = 0;
    if (kept_n > 0) begin
      if (kept_n % 2 == 0) twice = longint'(sorted[kept_n/2-1]) + longint'(sorted[kept_n/2]);
      else                 twice = 2 * longint'(sorted[kept_n/2]);
    end
    r.median_doubled = twice[mos_pkg::MED_W-1:0];
    r.set_count      = kept_n[mos_pkg::SETC_W-1:0];
    r.overflowed     = kept_ovf;
    r.empty_set      = (kept_n == 0);
    kept_n   = 0;
    kept_ovf = 0;
    return 1;
  endfunction

  // Offer one sample request and hold it until accepted. Called in the active region
  // right after a rising edge; the next call may follow in the same step, so valid
  // stays high across back-to-back requests.
  task automatic push_sample(input logic signed [mos_pkg::VAL_W-1:0] v, input logic l,
                             input bit typed, input median_result_t want);
    median_result_t got;
    in_valid        <= 1'b1;
    in_sample_value <= v;
    in_last_value   <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);   // pre-edge value: accepted at this edge
    if (take_sample(v, l, got)) begin
      pending_medians.push_back(typed ? want : got);
      sets_closed++;
    end
    samples_sent++;
  endtask

  // Sender pacing: bursts of random length, random gaps between them, and now and
  // then a long burst with no gap at all.
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 16);
    end
  endtask

  // Sender idles until every predicted median has come back.
  task automatic wait_all_medians();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_medians.size() != 0) @(posedge clk);
  endtask

  // Random sample values: extremes, near-extremes, a narrow band (many duplicates)
  // and full-range noise so every bit toggles.
  function automatic logic signed [mos_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFFFFFF;
      1:       return 32'sh80000000;
      2:       return $urandom_range(0, 20) - 10;
      3:       return 32'sh7FFFFFFF - $urandom_range(0, 3);
      4:       return 32'sh80000000 + $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  // Result checker: each result request is matched against the oldest prediction.
  always @(posedge clk) begin : result_check
    median_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_medians.size() == 0) begin
        $error("unexpected result: median_doubled %0d set_count %0d",
               out_median_doubled, out_set_count);
        errors++;
      end else begin
        want = pending_medians.pop_front();
        if (out_median_doubled !== want.median_doubled) begin
          $error("median_doubled: expected %0d, got %0d", want.median_doubled,
                 out_median_doubled);
          errors++;
        end
        if (out_set_count !== want.set_count) begin
          $error("set_count: expected %0d, got %0d", want.set_count, out_set_count);
          errors++;
        end
        if (out_overflowed !== want.overflowed) begin
          $error("overflowed: expected %0b, got %0b", want.overflowed, out_overflowed);
          errors++;
        end
        if (out_empty_set !== want.empty_set) begin
          $error("empty_set: expected %0b, got %0b", want.empty_set, out_empty_set);
          errors++;
        end
        medians_checked++;
      end
    end
  end

  // Receiver: stall pattern is drawn at random (always ready, 3 of 4, coin
  // flip, mostly stalled). Once, early in the random part, it holds off for a long
  // stretch so a finished median backs up and in_ready stays low.
  initial begin : result_sink
    int mode;
    int phase;
    mode  = 0;
    phase = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!long_hold_done && random_phase && medians_checked >= 3) begin
        long_hold_done = 1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (phase % 64 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= (phase % 4 != 0);
          2:       out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= (phase % 8 < 2);
        endcase
        phase++;
        @(posedge clk);
      end
    end
  end

  // Hang guard
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d medians still pending", cycles,
               pending_medians.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Stimulus
  initial begin : stimulus
    int set_size;
    int set_idx;
    int k;
    int rand_sent;

    // Directed sets. Typed results are the ones readable by eye.
    script.push_back(script_row_t'{1, 32'sd0, 1'b1, 1'b1, '{33'sd0, 9'd1, 1'b0, 1'b0}});
    script.push_back(script_row_t'{1, 32'sh7FFFFFFF, 1'b1, 1'b1,
                                   '{33'sh0FFFFFFFE, 9'd1, 1'b0, 1'b0}});
    script.push_back(script_row_t'{1, 32'sh80000000, 1'b1, 1'b1,
                                   '{33'sh100000000, 9'd1, 1'b0, 1'b0}});
    // max and min together: a subtracting compare would overflow here
    script.push_back(script_row_t'{1, 32'sh7FFFFFFF, 1'b0, 1'b0, '0});
    script.push_back(script_row_t'{1, 32'sh80000000, 1'b1, 1'b1,
                                   '{33'sh1FFFFFFFF, 9'd2, 1'b0, 1'b0}});
    // odd set spanning both extremes
    script.push_back(script_row_t'{1, 32'sh80000000, 1'b0, 1'b0, '0});
    script.push_back(script_row_t'{1, 32'sh7FFFFFFF, 1'b0, 1'b0, '0});
    script.push_back(script_row_t'{1, 32'sd5, 1'b1, 1'b0, '0});
    // even set with an odd sum of middles
    script.push_back(script_row_t'{1, -32'sd5, 1'b0, 1'b0, '0});
    script.push_back(script_row_t'{1, 32'sd9, 1'b0, 1'b0, '0});
    script.push_back(script_row_t'{1, 32'sd2, 1'b0, 1'b0, '0});
    script.push_back(script_row_t'{1, -32'sd100, 1'b1, 1'b0, '0});
    // duplicates
    script.push_back(script_row_t'{2, 32'sd7, 1'b0, 1'b0, '0});
    script.push_back(script_row_t'{1, -32'sd7, 1'b1, 1'b0, '0});
    // store exactly full
    script.push_back(script_row_t'{256, -32'sd1, 1'b1, 1'b1,
                                   '{-33'sd2, 9'd256, 1'b0, 1'b0}});
    // overflow: values past the store depth dropped
    script.push_back(script_row_t'{300, 32'sh80000000, 1'b1, 1'b1,
                                   '{33'sh100000000, 9'd256, 1'b1, 1'b0}});
    // overflow where only the closing value is dropped
    script.push_back(script_row_t'{256, 32'sd7, 1'b0, 1'b0, '0});
    script.push_back(script_row_t'{1, 32'sh7FFFFFFF, 1'b1, 1'b1,
                                   '{33'sd14, 9'd256, 1'b1, 1'b0}});
    // flags clear after an overflowed set
    script.push_back(script_row_t'{1, 32'sd3, 1'b1, 1'b1, '{33'sd6, 9'd1, 1'b0, 1'b0}});
    // alternating bit patterns
    script.push_back(script_row_t'{1, 32'sh55555555, 1'b0, 1'b0, '0});
    script.push_back(script_row_t'{1, 32'shAAAAAAAA, 1'b1, 1'b0, '0});

    // synchronous reset, held and then released
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[r]) begin
      for (k = 1; k <= script[r].reps; k++) begin
        push_sample(script[r].value, script[r].last && (k == script[r].reps),
                    script[r].typed, script[r].want);
        pace();
      end
    end
    ovf_sets    = 2;
    largest_set = 300;
    wait_all_medians();

    // Random sets: mostly small, a few near or at the store depth, a few past it.
    random_phase = 1;
    set_idx      = 0;
    rand_sent    = 0;
    while (rand_sent < RANDOM_SAMPLES) begin
      k = $urandom_range(0, 99);
      if (k < 2)      set_size = $urandom_range(257, 300);
      else if (k < 5) set_size = $urandom_range(200, 256);
      else            set_size = $urandom_range(1, 12);
      if (set_size > mos_pkg::SET_DEPTH) ovf_sets++;
      if (set_size > largest_set) largest_set = set_size;
      for (k = 1; k <= set_size; k++) begin
        push_sample(pick_value(), k == set_size, 1'b0, '0);
        rand_sent++;
        pace();
      end
      set_idx++;
      // now and then the sender waits for the block to empty out completely
      if (set_idx % 16 == 5) wait_all_medians();
    end

    wait_all_medians();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d sets from %0d samples, %0d of them overflowed, largest %0d",
             sets_closed, samples_sent, ovf_sets, largest_set);
    $display("checked %0d medians in %0d cycles, %0d mismatches",
             medians_checked, cycles, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
